FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, switched off while reset is held
`define ASSERT_SYNC(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/fspwm_pkg.sv
// ---------------------------------------------------------------------------
// fspwm_pkg
// Shared types and constants of the framed servo packet to PWM mapper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fspwm_pkg;

  // Number of compare fields on the result port
  localparam int OUT_FIELDS = 4;

  // Largest angle accepted; larger bytes are clamped to it
  localparam logic [7:0] ANGLE_LIMIT = 8'd180;

  // x / 180 is taken as (x >> 2) / 45; 45 by reciprocal with one correction
  localparam int QUOT_DIV    = 45;
  localparam int RECIP       = 93206;   // floor(2^22 / 45)
  localparam int RECIP_SHIFT = 22;

  // Register reset values
  localparam logic [7:0]  HEADER_RST = 8'hFF;
  localparam logic [7:0]  FOOTER_RST = 8'hFE;
  localparam logic [15:0] MIN_RST    = 16'd150;
  localparam logic [15:0] MAX_RST    = 16'd600;
  localparam logic [15:0] PERIOD_RST = 16'd4999;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_HEADER = 3'd0,
    CFG_FOOTER = 3'd1,
    CFG_MIN    = 3'd2,
    CFG_MAX    = 3'd3,
    CFG_PERIOD = 3'd4
  } fspwm_cfg_idx_t;

  // Stage load enables handed from the pipeline control to each lane
  typedef struct packed {
    logic p_en;
    logic d_en;
    logic o_en;
  } fspwm_adv_t;

endpackage

`default_nettype wire

FILE: rtl/framed_servo_packet_to_pwm_top.sv
// Framed servo packet to PWM compare mapper.
// Throughput: one byte per cycle while in_ready is high; a frame is CHANNELS + 2 bytes.
// The result beat passes the frame register (loaded on the edge that accepts the footer
// beat), then the product, quotient and output registers; back-pressure can hold any stage.
// Reset: synchronous, active low; clears the parser and all valid flags and
// loads the register defaults. Angle storage is not cleared.
// ---------------------------------------------------------------------------
// framed_servo_packet_to_pwm_top
// Configuration registers, pipeline valid chain and the mapping lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module framed_servo_packet_to_pwm_top import fspwm_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_base_compare,
  output logic [15:0]      out_shoulder_compare,
  output logic [15:0]      out_elbow_compare,
  output logic [15:0]      out_claw_compare,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int LANES = (CHANNELS < OUT_FIELDS) ? CHANNELS : OUT_FIELDS;

  logic [7:0]  header_r;
  logic [7:0]  footer_r;
  logic [15:0] min_r;
  logic [15:0] max_r;
  logic [15:0] period_r;
  logic [15:0] span_w;

  logic                  frame_valid;
  logic [LANES-1:0][7:0] frame_angle;
  logic                  p_valid_r, d_valid_r, o_valid_r;
  logic                  p_ready, d_ready, o_ready, f_ready;
  logic                  in_fire;
  fspwm_adv_t            adv;

  logic [15:0]                 lane_cmp [LANES];
  logic [OUT_FIELDS-1:0][15:0] cmp_all;

  // Write configuration registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      footer_r <= FOOTER_RST;
      min_r    <= MIN_RST;
      max_r    <= MAX_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER: header_r <= cfg_data[7:0];
        CFG_FOOTER: footer_r <= cfg_data[7:0];
        CFG_MIN:    min_r    <= cfg_data;
        CFG_MAX:    max_r    <= cfg_data;
        CFG_PERIOD: period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Span collapses to zero when max is below min
  assign span_w = (max_r >= min_r) ? max_r - min_r : 16'd0;

  // Ready chain: a stage takes a beat when empty or when it is draining
  assign o_ready  = !o_valid_r || out_ready;
  assign d_ready  = !d_valid_r || o_ready;
  assign p_ready  = !p_valid_r || d_ready;
  assign f_ready  = !frame_valid || p_ready;
  assign in_ready = f_ready;
  assign in_fire  = in_valid && in_ready;

  assign adv.p_en = frame_valid && p_ready;
  assign adv.d_en = p_valid_r && d_ready;
  assign adv.o_en = d_valid_r && o_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (p_ready) p_valid_r <= frame_valid;
      if (d_ready) d_valid_r <= p_valid_r;
      if (o_ready) o_valid_r <= d_valid_r;
    end
  end

  fspwm_parser #(
    .CHANNELS (CHANNELS),
    .LANES    (LANES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_fire    (in_fire),
    .rx_byte      (in_rx_byte),
    .header_value (header_r),
    .footer_value (footer_r),
    .frame_take   (p_ready),
    .frame_valid  (frame_valid),
    .frame_angle  (frame_angle)
  );

  // One mapping lane per channel given out
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fspwm_lane u_lane (
      .clk         (clk),
      .adv         (adv),
      .angle       (frame_angle[g]),
      .span        (span_w),
      .min_pulse   (min_r),
      .period_load (period_r),
      .compare     (lane_cmp[g])
    );
  end

  // Tie off result fields with no channel behind them
  for (genvar g = 0; g < OUT_FIELDS; g++) begin : g_out
    if (g < LANES) begin : g_used
      assign cmp_all[g] = lane_cmp[g];
    end else begin : g_zero
      assign cmp_all[g] = 16'd0;
    end
  end

  assign out_valid            = o_valid_r;
  assign out_base_compare     = cmp_all[0];
  assign out_shoulder_compare = cmp_all[1];
  assign out_elbow_compare    = cmp_all[2];
  assign out_claw_compare     = cmp_all[3];

endmodule

`default_nettype wire

FILE: rtl/fspwm_parser.sv
// ---------------------------------------------------------------------------
// fspwm_parser
// Frame parser: header, angle bytes, footer; holds one clamped frame beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fspwm_parser import fspwm_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int LANES    = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   byte_fire,
  input  wire logic [7:0]             rx_byte,
  input  wire logic [7:0]             header_value,
  input  wire logic [7:0]             footer_value,
  input  wire logic                   frame_take,
  output logic                        frame_valid,
  output logic [LANES-1:0][7:0]       frame_angle
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DATA = 3'b010,
    PH_FOOT = 3'b100
  } fspwm_phase_t;

  fspwm_phase_t          phase_r, phase_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [7:0]            angle_store [LANES];
  logic [LANES-1:0][7:0] angle_r;
  logic                  fv_r, fv_nxt;
  logic                  frame_load;
  logic                  last_byte;
  logic                  store_en;

  assign last_byte  = (cnt_r == CW'(CHANNELS - 1));
  assign store_en   = byte_fire && (phase_r == PH_DATA) &&
                      ({1'b0, cnt_r} < (CW + 1)'(LANES));
  assign frame_load = byte_fire && (phase_r == PH_FOOT) && (rx_byte == footer_value);

  // Advance the frame phase on each accepted byte
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (byte_fire) begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_byte == header_value) begin
            phase_nxt = PH_DATA;
            cnt_nxt   = '0;
          end
        end
        PH_DATA: begin
          if (last_byte) begin
            phase_nxt = PH_FOOT;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        PH_FOOT: begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
        end
        default: begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  // Hold a frame beat until the next stage takes it
  always_comb begin
    if (frame_load) begin
      fv_nxt = 1'b1;
    end else if (frame_take) begin
      fv_nxt = 1'b0;
    end else begin
      fv_nxt = fv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      fv_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      fv_r    <= fv_nxt;
    end
  end

  // Store data bytes clamped to the angle limit
  always_ff @(posedge clk) begin
    if (store_en) begin
      angle_store[cnt_r[LW-1:0]] <= (rx_byte > ANGLE_LIMIT) ? ANGLE_LIMIT : rx_byte;
    end
  end

  // Copy the finished frame on a matching footer
  always_ff @(posedge clk) begin
    if (frame_load) begin
      for (int i = 0; i < LANES; i++) begin
        angle_r[i] <= angle_store[i];
      end
    end
  end

  assign frame_valid = fv_r;
  assign frame_angle = angle_r;

endmodule

`default_nettype wire

FILE: rtl/fspwm_lane.sv
// ---------------------------------------------------------------------------
// fspwm_lane
// Angle to compare value for one channel, three register stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fspwm_lane import fspwm_pkg::*; (
  input  wire logic        clk,
  input  wire fspwm_adv_t  adv,
  input  wire logic [7:0]  angle,
  input  wire logic [15:0] span,
  input  wire logic [15:0] min_pulse,
  input  wire logic [15:0] period_load,
  output logic [15:0]      compare
);

  logic [23:0] prod_w;
  logic [38:0] rprod_w;
  logic [21:0] back_w;
  logic [21:0] rem_w;
  logic [15:0] quot_w;
  logic [16:0] pulse_w;
  logic [15:0] cmp_w;

  logic [21:0] x_r;
  logic [21:0] x2_r;
  logic [15:0] q0_r;
  logic [15:0] cmp_r;

  // Scale angle by span; the two low bits drop out of the divide by 180
  assign prod_w = {16'd0, angle} * {8'd0, span};

  always_ff @(posedge clk) begin
    if (adv.p_en) begin
      x_r <= prod_w[23:2];
    end
  end

  // Estimate the quotient by 45; it is exact or one short
  assign rprod_w = {17'd0, x_r} * 39'(RECIP);

  always_ff @(posedge clk) begin
    if (adv.d_en) begin
      q0_r <= rprod_w[RECIP_SHIFT+15:RECIP_SHIFT];
      x2_r <= x_r;
    end
  end

  // Correct the quotient, add the minimum and subtract from the period, clamping at zero
  assign back_w  = {6'd0, q0_r} * 22'(QUOT_DIV);
  assign rem_w   = x2_r - back_w;
  assign quot_w  = (rem_w >= 22'(QUOT_DIV)) ? q0_r + 16'd1 : q0_r;
  assign pulse_w = {1'b0, min_pulse} + {1'b0, quot_w};
  assign cmp_w   = (pulse_w > {1'b0, period_load}) ? 16'd0 : period_load - pulse_w[15:0];

  always_ff @(posedge clk) begin
    if (adv.o_en) begin
      cmp_r <= cmp_w;
    end
  end

  assign compare = cmp_r;

endmodule

`default_nettype wire

FILE: rtl/fspwm_checker.sv
// ---------------------------------------------------------------------------
// fspwm_checker
// Port level checks on the mapper, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fspwm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_base_compare,
  input wire logic [15:0] out_shoulder_compare,
  input wire logic [15:0] out_elbow_compare,
  input wire logic [15:0] out_claw_compare
);

  // A result beat stays offered until taken
  `ASSERT_SYNC(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")

  // A stalled result beat keeps its payload
  `ASSERT_SYNC(a_out_stable, out_valid && !out_ready |=> $stable(out_base_compare) && $stable(out_shoulder_compare) && $stable(out_elbow_compare) && $stable(out_claw_compare), "stalled result changed")

  // A draining output side never back-pressures the byte input
  `ASSERT_SYNC(a_in_flow, !out_valid || out_ready |-> in_ready, "input stalled with output free")

  // Reset empties the result register
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind framed_servo_packet_to_pwm_top fspwm_checker u_fspwm_checker (.*);

`default_nettype wire
